FILE: rtl/mfcc_pkg.sv
// Package with the shared types, constants and CRC step function of the Modbus frame checker.
`default_nettype none

package mfcc_pkg;

	// CRC-16 Modbus constants.
	localparam logic [15:0] CRC_START = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;

	// Reset value of the minimum frame length register.
	localparam logic [7:0] MIN_LEN_RESET = 8'd5;

	// Width of the reported frame length.
	localparam int LEN_OUT_W = 9;

	// Frame status codes.
	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_CRC_ERR = 2'd1,
		STATUS_SHORT   = 2'd2,
		STATUS_LONG    = 2'd3
	} frame_status_t;

	// One accepted byte word held in the input stage.
	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
		logic       end_of_frame;
	} byte_word_t;

	// One frame report.
	typedef struct packed {
		frame_status_t          frame_status;
		logic [LEN_OUT_W-1:0]   frame_length;
		logic [15:0]            received_check;
		logic [15:0]            computed_check;
	} report_word_t;

	// Reflected CRC-16 update over one byte, eight shift steps unrolled.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/mfcc_if.sv
// Valid/ready channel interfaces for frame bytes and frame reports.
`default_nettype none

interface mfcc_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_frame;

	modport source (output valid, output data_byte, output end_of_frame, input ready);
	modport sink   (input valid, input data_byte, input end_of_frame, output ready);
endinterface

interface mfcc_report_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [8:0]  frame_length;
	logic [15:0] received_check;
	logic [15:0] computed_check;

	modport source (output valid, output frame_status, output frame_length,
		output received_check, output computed_check, input ready);
	modport sink   (input valid, input frame_status, input frame_length,
		input received_check, input computed_check, output ready);
endinterface

`default_nettype wire

FILE: rtl/modbus_frame_crc_checker_core.sv
// Top level of the Modbus RTU frame CRC checker.
//
//   channel  | dir | word                                   | when
//   rx       | in  | data_byte, end_of_frame                | every frame byte
//   report   | out | frame_status, frame_length, checks     | one per frame, on last byte
//   cfg      | in  | min_frame_length (8 bit)               | write enable, no read-back
//
// One byte word per cycle sustained unless a stalled report holds the input; a byte goes through the
// input register and the frame logic, and a frame's report is registered in the result register.
// The CRC update for a byte is one unrolled eight-step pass between those two registers.
// Reset clears the handshake flags and the frame state and loads min_frame_length with 5.
// A stalled report holds the last byte of the next frame in the input register; bytes
// before it keep flowing, and the input stalls once that last byte is waiting.
`default_nettype none

module modbus_frame_crc_checker_core
	import mfcc_pkg::*;
#(
	parameter int MAX_BYTES = 256
) (
	input  wire           clk,
	input  wire           arst_n,
	mfcc_byte_if.sink     rx,
	mfcc_report_if.source report,
	input  wire           cfg_wr_en,
	input  wire [7:0]     cfg_wr_data
);

	byte_word_t   word;
	report_word_t next_report;
	logic         take;
	logic         busy;
	logic [7:0]   min_len_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
		end else if (cfg_wr_en) begin
			min_len_q <= cfg_wr_data;
		end
	end

	// A held word moves on unless it ends a frame and the result register is full and not being taken.
	assign take = word.valid && (!word.end_of_frame || !busy || report.ready);

	mfcc_in_reg u_in_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.take   (take),
		.word   (word)
	);

	mfcc_frame_track #(
		.MAX_BYTES (MAX_BYTES)
	) u_frame_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.word    (word),
		.take    (take),
		.min_len (min_len_q),
		.report  (next_report)
	);

	mfcc_out_reg u_out_reg (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take && word.end_of_frame),
		.next_report (next_report),
		.report      (report),
		.busy        (busy)
	);

endmodule

`default_nettype wire

FILE: rtl/mfcc_in_reg.sv
// Input register stage that holds one accepted byte word until the frame logic takes it.
`default_nettype none

module mfcc_in_reg
	import mfcc_pkg::*;
(
	input  wire          clk,
	input  wire          arst_n,
	mfcc_byte_if.sink    rx,
	input  wire          take,
	output byte_word_t   word
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// The stage is free when empty or when its word leaves this cycle.
	assign rx.ready = !valid_s1 || take;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the stage.
	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data_byte;
			last_s1 <= rx.end_of_frame;
		end
	end

	assign word = '{valid: valid_s1, data_byte: byte_s1, end_of_frame: last_s1};

endmodule

`default_nettype wire

FILE: rtl/mfcc_frame_track.sv
// Frame state: running CRC, two-byte delay, byte count, and report formation on the last byte.
`default_nettype none

module mfcc_frame_track
	import mfcc_pkg::*;
#(
	parameter int MAX_BYTES = 256
) (
	input  wire          clk,
	input  wire          arst_n,
	input  byte_word_t   word,
	input  wire          take,
	input  wire [7:0]    min_len,
	output report_word_t report
);

	localparam int CNT_W = $clog2(MAX_BYTES + 1);
	localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

	logic [15:0]      crc_q;
	logic [7:0]       newest_q;
	logic [7:0]       older_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	logic [15:0]      crc_mid;
	logic             at_max;
	logic             ovf_next;
	logic [CNT_W-1:0] count_next;
	logic [15:0]      received;
	frame_status_t    status;

	// The oldest delayed byte enters the CRC once two bytes sit behind it.
	always_comb begin
		if ((count_q >= CNT_W'(2)) || ovf_q) begin
			crc_mid = crc16_byte(crc_q, older_q);
		end else begin
			crc_mid = crc_q;
		end
	end

	// Byte count saturates at the maximum and sets the overflow flag.
	assign at_max     = (count_q >= CNT_W'(MAX_BYTES));
	assign ovf_next   = ovf_q || at_max;
	assign count_next = at_max ? count_q : (count_q + CNT_W'(1));

	// Received CRC, last byte high, and status by priority.
	assign received = {word.data_byte, newest_q};

	always_comb begin
		if (ovf_next) begin
			status = STATUS_LONG;
		end else if (CMP_W'(count_next) < CMP_W'(min_len)) begin
			status = STATUS_SHORT;
		end else if (received != crc_mid) begin
			status = STATUS_CRC_ERR;
		end else begin
			status = STATUS_OK;
		end
	end

	assign report = '{
		frame_status:   status,
		frame_length:   LEN_OUT_W'(count_next),
		received_check: received,
		computed_check: crc_mid
	};

	// State update; the last byte returns the frame state to its start values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= CRC_START;
			newest_q <= 8'h00;
			older_q  <= 8'h00;
			count_q  <= '0;
			ovf_q    <= 1'b0;
		end else if (take) begin
			if (word.end_of_frame) begin
				crc_q    <= CRC_START;
				newest_q <= 8'h00;
				older_q  <= 8'h00;
				count_q  <= '0;
				ovf_q    <= 1'b0;
			end else begin
				crc_q    <= crc_mid;
				newest_q <= word.data_byte;
				older_q  <= newest_q;
				count_q  <= count_next;
				ovf_q    <= ovf_next;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/mfcc_out_reg.sv
// Result register that holds one frame report until the sink takes it.
`default_nettype none

module mfcc_out_reg
	import mfcc_pkg::*;
(
	input  wire           clk,
	input  wire           arst_n,
	input  wire           load,
	input  report_word_t  next_report,
	mfcc_report_if.source report,
	output logic          busy
);

	logic         valid_q;
	report_word_t word_q;

	// Valid flag: set on a new report, cleared once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (report.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Report payload.
	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= next_report;
		end
	end

	assign busy                  = valid_q;
	assign report.valid          = valid_q;
	assign report.frame_status   = word_q.frame_status;
	assign report.frame_length   = word_q.frame_length;
	assign report.received_check = word_q.received_check;
	assign report.computed_check = word_q.computed_check;

endmodule

`default_nettype wire

FILE: rtl/mfcc_checker.sv
// Port-level assertions for the frame checker, bound to the top level.
`default_nettype none

module mfcc_checker
	import mfcc_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        report_valid,
	input wire        report_ready,
	input wire [1:0]  frame_status,
	input wire [8:0]  frame_length,
	input wire [15:0] received_check,
	input wire [15:0] computed_check
);

	// A report waits until it is taken.
	a_report_holds: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> report_valid)
		else $error("report word dropped before it was taken");

	// A stalled report keeps its payload.
	a_report_stable: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && !report_ready |=> $stable(frame_status) && $stable(frame_length)
			&& $stable(received_check) && $stable(computed_check))
		else $error("stalled report word changed");

	// An ok status means the two checks agree.
	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && (frame_status == STATUS_OK) |-> (received_check == computed_check))
		else $error("ok status with differing checks");

	// A mismatch status means the two checks differ.
	a_err_differ: assert property (@(posedge clk) disable iff (!arst_n)
		report_valid && (frame_status == STATUS_CRC_ERR) |->
			(received_check != computed_check))
		else $error("crc mismatch status with equal checks");

endmodule

bind modbus_frame_crc_checker_core mfcc_checker u_mfcc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.report_valid   (report.valid),
	.report_ready   (report.ready),
	.frame_status   (report.frame_status),
	.frame_length   (report.frame_length),
	.received_check (report.received_check),
	.computed_check (report.computed_check)
);

`default_nettype wire
